@@ rtl/core/tccw_pkg.sv @@
// Shared constants, codes and helper functions for the text console cell writer.
package tccw_pkg;

   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int NCELLS = ROWS * COLS;
   localparam int ADDR_W = $clog2(NCELLS);
   localparam int LIN_W  = ADDR_W + 1;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int POS_W  = 11;
   localparam int IDX_W  = 11;
   localparam int BYTE_W = 8;
   localparam int ACT_W  = 2;
   localparam int SEL_W  = 2;

   localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

   localparam logic [SEL_W-1:0] COLOUR_KEEP  = 2'd0;
   localparam logic [SEL_W-1:0] COLOUR_GREEN = 2'd1;
   localparam logic [SEL_W-1:0] COLOUR_BLUE  = 2'd2;
   localparam logic [SEL_W-1:0] COLOUR_ROSE  = 2'd3;

   localparam logic [BYTE_W-1:0] ATTR_GREEN = 8'h20;
   localparam logic [BYTE_W-1:0] ATTR_BLUE  = 8'h36;
   localparam logic [BYTE_W-1:0] ATTR_ROSE  = 8'h50;

   function automatic logic [BYTE_W-1:0] colour_attr(input logic [SEL_W-1:0] sel);
      logic [BYTE_W-1:0] attr;
      unique case (sel)
         COLOUR_GREEN: attr = ATTR_GREEN;
         COLOUR_BLUE:  attr = ATTR_BLUE;
         COLOUR_ROSE:  attr = ATTR_ROSE;
         default:      attr = '0;
      endcase
      return attr;
   endfunction

   function automatic logic [LIN_W-1:0] cell_lin(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
      return LIN_W'(row) * LIN_W'(COLS) + LIN_W'(col);
   endfunction

endpackage

@@ rtl/core/tccw_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module tccw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/text_console_cell_writer_core.sv @@
// Text console cell writer: cursor control, cell store sweeps and response register.
// Read, no-op and non-scrolling puts go from accept to ST_DONE, which loads the response when free.
// A line feed or wrap off the last row scrolls: a copy pass moves rows up a line and a fill
// pass blanks the last row, paced by the single cell store read and write port. Clear
// screen blanks all cells. One request in flight; the next is taken while a finished
// response still waits. Reset: a clearing pass zeroes all 2000 cells with req_ready low.
module text_console_cell_writer_core
   import tccw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [BYTE_W-1:0] req_char_code,
   input  logic [IDX_W-1:0]  req_cell_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [POS_W-1:0]  rsp_cursor_position,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [BYTE_W-1:0] rsp_read_char,
   output logic [BYTE_W-1:0] rsp_read_attr,
   input  logic              csr_wr_en,
   input  logic [SEL_W-1:0]  csr_wr_data
);

   typedef enum logic [4:0] {
      ST_INIT = 5'b00001,
      ST_IDLE = 5'b00010,
      ST_COPY = 5'b00100,
      ST_FILL = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              flag_ff, flag_in;
   logic              rd_item_ff, rd_item_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SEL_W-1:0]  colour_ff;

   logic [POS_W-1:0]  rsp_pos_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [BYTE_W-1:0] rsp_char_ff;
   logic [BYTE_W-1:0] rsp_attr_ff;

   logic              accept;
   logic              advance;
   logic              load_rsp;
   logic [LIN_W-1:0]  lin_cur;
   logic [LIN_W-1:0]  lin_back;

   logic              wr_en;
   logic              wr_attr_force;
   logic              attr_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_char;
   logic [BYTE_W-1:0] wr_attr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_char;
   logic [BYTE_W-1:0] rd_attr;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign lin_cur   = cell_lin(row_ff, col_ff);
   assign lin_back  = lin_cur - LIN_W'(1);
   assign attr_we   = wr_en && (wr_attr_force || (colour_ff != COLOUR_KEEP));

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      flag_in       = flag_ff;
      rd_item_in    = rd_item_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      load_rsp      = 1'b0;
      advance       = 1'b0;
      wr_en         = 1'b0;
      wr_attr_force = 1'b0;
      wr_addr       = '0;
      wr_char       = CH_NUL;
      wr_attr       = colour_attr(colour_ff);
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         ST_INIT: begin
            wr_en         = 1'b1;
            wr_attr_force = 1'b1;
            wr_addr       = sweep_ff;
            wr_attr       = '0;
            if (sweep_ff == ADDR_W'(NCELLS - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rd_item_in = 1'b0;
               state_in   = ST_DONE;
               unique case (req_action)
                  ACT_PUT: begin
                     priority if (req_char_code == CH_NUL || req_char_code == CH_TAB) begin
                     end else if (req_char_code == CH_LF || req_char_code == CH_CR) begin
                        advance = 1'b1;
                        flag_in = 1'b1;
                     end else if (req_char_code == CH_BS) begin
                        if (flag_ff) begin
                           wr_en = 1'b1;
                           if (col_ff != '0) begin
                              col_in  = col_ff - COL_W'(1);
                              wr_addr = ADDR_W'(lin_back);
                           end else begin
                              wr_addr = ADDR_W'(lin_cur);
                           end
                        end else if (col_ff == '0) begin
                           if (row_ff != '0) begin
                              wr_en   = 1'b1;
                              wr_addr = ADDR_W'(lin_back);
                              row_in  = row_ff - ROW_W'(1);
                              col_in  = COL_W'(COLS);
                           end
                           flag_in = 1'b1;
                        end else begin
                           wr_en   = 1'b1;
                           wr_addr = ADDR_W'(lin_back);
                           col_in  = col_ff - COL_W'(1);
                           if (col_ff == COL_W'(1)) begin
                              if (row_ff != '0) begin
                                 row_in = row_ff - ROW_W'(1);
                                 col_in = COL_W'(COLS);
                              end
                              flag_in = 1'b1;
                           end
                        end
                     end else begin
                        if (lin_cur < LIN_W'(NCELLS)) begin
                           wr_en   = 1'b1;
                           wr_addr = ADDR_W'(lin_cur);
                           wr_char = req_char_code;
                        end
                        col_in = col_ff + COL_W'(1);
                        if (col_ff >= COL_W'(COLS - 1)) begin
                           advance = 1'b1;
                           flag_in = 1'b0;
                        end
                     end
                     if (advance) begin
                        col_in = '0;
                        if (row_ff == ROW_W'(ROWS - 1)) begin
                           sweep_in = '0;
                           state_in = ST_COPY;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                        end
                     end
                  end
                  ACT_READ: begin
                     if (req_cell_index < IDX_W'(NCELLS)) begin
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(req_cell_index);
                        rd_item_in = 1'b1;
                     end
                  end
                  ACT_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     sweep_in = '0;
                     state_in = ST_FILL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COPY: begin
            if (sweep_ff < ADDR_W'(NCELLS - COLS)) begin
               rd_en   = 1'b1;
               rd_addr = sweep_ff + ADDR_W'(COLS);
            end
            if (sweep_ff != '0) begin
               wr_en         = 1'b1;
               wr_attr_force = 1'b1;
               wr_addr       = sweep_ff - ADDR_W'(1);
               wr_char       = rd_char;
               wr_attr       = rd_attr;
            end
            if (sweep_ff == ADDR_W'(NCELLS - COLS)) begin
               state_in = ST_FILL;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_char = CH_SPACE;
            if (sweep_ff == ADDR_W'(NCELLS - 1)) begin
               sweep_in = '0;
               state_in = ST_DONE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         flag_ff      <= 1'b1;
         rd_item_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         colour_ff    <= COLOUR_KEEP;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         flag_ff      <= flag_in;
         rd_item_ff   <= rd_item_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            colour_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_pos_ff  <= lin_cur[POS_W-1:0];
         rsp_col_ff  <= col_ff;
         rsp_row_ff  <= row_ff;
         rsp_char_ff <= rd_item_ff ? rd_char : '0;
         rsp_attr_ff <= rd_item_ff ? rd_attr : '0;
      end
   end

   tccw_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (NCELLS)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_char),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_char)
   );

   tccw_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (NCELLS)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (wr_addr),
      .wr_data (wr_attr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_attr)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cursor_col      = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_read_char       = rsp_char_ff;
   assign rsp_read_attr       = rsp_attr_ff;

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff < ROW_W'(ROWS))
      else $error("cursor row beyond last row");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(COLS))
      else $error("cursor column beyond line end");

   a_no_stray_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !accept) |-> !wr_en)
      else $error("cell store written while idle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE && !req_ready))
      else $error("request accepted without starting work");

endmodule

@@ bench/tb.sv @@
// Testbench for text_console_cell_writer_core: directed table, random traffic, predictor.
module tb;
   import tccw_pkg::*;

   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SWEEP_BUDGET = 90;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [BYTE_W-1:0] ch;
      logic [BYTE_W-1:0] attr;
   } cursor_report_type;

   typedef struct packed {
      logic [ACT_W-1:0]  act;
      logic [BYTE_W-1:0] ch;
      logic [IDX_W-1:0]  idx;
      logic [7:0]        reps;
      logic              typed;
      cursor_report_type rep;
   } script_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ACT_W-1:0]  req_action = '0;
   logic [BYTE_W-1:0] req_char_code = '0;
   logic [IDX_W-1:0]  req_cell_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [POS_W-1:0]  rsp_cursor_position;
   logic [COL_W-1:0]  rsp_cursor_col;
   logic [ROW_W-1:0]  rsp_cursor_row;
   logic [BYTE_W-1:0] rsp_read_char;
   logic [BYTE_W-1:0] rsp_read_attr;
   logic csr_wr_en = 1'b0;
   logic [SEL_W-1:0] csr_wr_data = '0;

   text_console_cell_writer_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_char_code(req_char_code),
      .req_cell_index(req_cell_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cursor_position(rsp_cursor_position),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_read_char(rsp_read_char),
      .rsp_read_attr(rsp_read_attr),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // console state as the block should hold it
   logic [2*BYTE_W-1:0] screen [NCELLS];
   logic [COL_W-1:0] cur_x;
   logic [ROW_W-1:0] cur_y;
   logic line_wrapped;
   logic [SEL_W-1:0] colour_sel;

   cursor_report_type pending_reports[$];
   script_step_type script[$];
   int bad_reports = 0;
   int cycle_count = 0;
   int sweeps = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;

   function automatic void console_reset();
      for (int i = 0; i < NCELLS; i++) screen[i] = '0;
      cur_x = '0;
      cur_y = '0;
      line_wrapped = 1'b1;
      colour_sel = COLOUR_KEEP;
   endfunction

   function automatic void poke_cell(int idx, logic [BYTE_W-1:0] ch);
      logic [BYTE_W-1:0] attr;
      if (idx >= NCELLS) return;
      case (colour_sel)
         COLOUR_GREEN: attr = ATTR_GREEN;
         COLOUR_BLUE:  attr = ATTR_BLUE;
         COLOUR_ROSE:  attr = ATTR_ROSE;
         default:      attr = screen[idx][2*BYTE_W-1:BYTE_W];
      endcase
      screen[idx] = {attr, ch};
   endfunction

   function automatic void blank_line(int r);
      for (int c = 0; c < COLS; c++) poke_cell(r * COLS + c, CH_SPACE);
   endfunction

   function automatic void line_feed();
      int y;
      y = int'(cur_y) + 1;
      cur_x = '0;
      if (y >= ROWS) begin
         for (int i = 0; i < NCELLS - COLS; i++) screen[i] = screen[i + COLS];
         blank_line(ROWS - 1);
         y = ROWS - 1;
      end
      cur_y = ROW_W'(y);
   endfunction

   function automatic void type_char(logic [BYTE_W-1:0] c);
      if (c == CH_NUL || c == CH_TAB) return;
      if (c == CH_LF || c == CH_CR) begin
         line_feed();
         line_wrapped = 1'b1;
         return;
      end
      if (c == CH_BS) begin
         if (line_wrapped) begin
            if (cur_x != 0) cur_x = cur_x - 1'b1;
            poke_cell(int'(cur_y) * COLS + int'(cur_x), CH_NUL);
         end else if (cur_x == 0) begin
            if (cur_y != 0) begin
               poke_cell(int'(cur_y) * COLS - 1, CH_NUL);
               cur_y = cur_y - 1'b1;
               cur_x = COL_W'(COLS);
            end
            line_wrapped = 1'b1;
         end else begin
            cur_x = cur_x - 1'b1;
            poke_cell(int'(cur_y) * COLS + int'(cur_x), CH_NUL);
            if (cur_x == 0) begin
               if (cur_y != 0) begin
                  cur_y = cur_y - 1'b1;
                  cur_x = COL_W'(COLS);
               end
               line_wrapped = 1'b1;
            end
         end
         return;
      end
      poke_cell(int'(cur_y) * COLS + int'(cur_x), c);
      cur_x = cur_x + 1'b1;
      if (int'(cur_x) >= COLS) begin
         line_feed();
         line_wrapped = 1'b0;
      end
   endfunction

   function automatic cursor_report_type advance_console(logic [ACT_W-1:0] act,
                                                         logic [BYTE_W-1:0] ch,
                                                         logic [IDX_W-1:0] idx);
      cursor_report_type r;
      r = '0;
      case (act)
         ACT_PUT: type_char(ch);
         ACT_READ: begin
            if (int'(idx) < NCELLS) begin
               r.ch   = screen[idx][BYTE_W-1:0];
               r.attr = screen[idx][2*BYTE_W-1:BYTE_W];
            end
         end
         ACT_CLEAR: begin
            for (int y = 0; y < ROWS; y++) blank_line(y);
            cur_x = '0;
            cur_y = '0;
         end
         default: ;
      endcase
      r.pos = POS_W'(int'(cur_y) * COLS + int'(cur_x));
      r.col = cur_x;
      r.row = cur_y;
      return r;
   endfunction

   function automatic logic starts_sweep(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] ch);
      if (act == ACT_CLEAR) return 1'b1;
      if (act != ACT_PUT || int'(cur_y) != ROWS - 1) return 1'b0;
      if (ch == CH_LF || ch == CH_CR) return 1'b1;
      if (ch == CH_NUL || ch == CH_TAB || ch == CH_BS) return 1'b0;
      return int'(cur_x) + 1 >= COLS;
   endfunction

   function automatic void add_step(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] ch,
                                    logic [IDX_W-1:0] idx, int reps, logic typed,
                                    int pos, int col, int row, int rc, int ra);
      script_step_type s;
      s.act = act;
      s.ch = ch;
      s.idx = idx;
      s.reps = 8'(reps);
      s.typed = typed;
      s.rep.pos = POS_W'(pos);
      s.rep.col = COL_W'(col);
      s.rep.row = ROW_W'(row);
      s.rep.ch = BYTE_W'(rc);
      s.rep.attr = BYTE_W'(ra);
      script.push_back(s);
   endfunction

   // entered just after a falling edge, leaves just after a later one
   task automatic issue_request(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] ch,
                                logic [IDX_W-1:0] idx, logic typed,
                                cursor_report_type typed_rep);
      cursor_report_type rep;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_char_code <= ch;
      req_cell_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rep = advance_console(act, ch, idx);
      pending_reports.push_back(typed ? typed_rep : rep);
      @(negedge clock);
   endtask

   task automatic pick_request(output logic [ACT_W-1:0] act, output logic [BYTE_W-1:0] ch,
                               output logic [IDX_W-1:0] idx);
      int roll;
      int here;
      roll = $urandom_range(99);
      ch = BYTE_W'($urandom_range(255));
      idx = IDX_W'($urandom_range(2047));
      if (roll < 1) begin
         act = ACT_CLEAR;
      end else if (roll < 3) begin
         act = ACT_UNUSED;
      end else if (roll < 28) begin
         act = ACT_READ;
         roll = $urandom_range(99);
         here = int'(cur_y) * COLS + int'(cur_x);
         if (roll < 70) idx = IDX_W'($urandom_range(NCELLS - 1));
         else if (roll < 85) idx = IDX_W'(here >= 100 ? here - $urandom_range(100) : here);
      end else begin
         act = ACT_PUT;
         roll = $urandom_range(99);
         if (roll < 60) ch = BYTE_W'($urandom_range(8'h7E, 8'h20));
         else if (roll < 70) ch = BYTE_W'($urandom_range(255));
         else if (roll < 74) ch = CH_LF;
         else if (roll < 77) ch = CH_CR;
         else if (roll < 88) ch = CH_BS;
         else if (roll < 90) ch = CH_NUL;
         else if (roll < 92) ch = CH_TAB;
         else ch = BYTE_W'($urandom_range(8'h7E, 8'h20));
      end
      // keep full-screen sweeps within the cycle budget
      if (starts_sweep(act, ch) && sweeps >= SWEEP_BUDGET) act = ACT_READ;
      if (starts_sweep(act, ch)) sweeps++;
   endtask

   task automatic run_random(int n);
      logic [ACT_W-1:0] act;
      logic [BYTE_W-1:0] ch;
      logic [IDX_W-1:0] idx;
      repeat (n) begin
         pick_request(act, ch, idx);
         issue_request(act, ch, idx, 1'b0, '0);
      end
   endtask

   // drop valid and wait for every outstanding response
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_colour(logic [SEL_W-1:0] sel);
      csr_wr_en <= 1'b1;
      csr_wr_data <= sel;
      colour_sel = sel;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cursor_report_type got;
      cursor_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.pos = rsp_cursor_position;
         got.col = rsp_cursor_col;
         got.row = rsp_cursor_row;
         got.ch = rsp_read_char;
         got.attr = rsp_read_attr;
         if (pending_reports.size() == 0) begin
            bad_reports++;
            if (bad_reports <= 10)
               $display("unexpected response pos=%0d col=%0d row=%0d char=%h attr=%h",
                        got.pos, got.col, got.row, got.ch, got.attr);
         end else begin
            want = pending_reports.pop_front();
            if (got.pos !== want.pos || got.col !== want.col || got.row !== want.row ||
                got.ch !== want.ch || got.attr !== want.attr) begin
               bad_reports++;
               if (bad_reports <= 10)
                  $display({"response differs: pos %0d/%0d col %0d/%0d row %0d/%0d ",
                            "char %h/%h attr %h/%h (expected/actual)"},
                           want.pos, got.pos, want.col, got.col, want.row, got.row,
                           want.ch, got.ch, want.attr, got.attr);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("text_console_cell_writer_core: mismatch");
         $finish;
      end
   end

   initial begin
      script_step_type s;
      console_reset();

      add_step(ACT_READ,   CH_NUL, 11'd0,    1, 1'b1, 0, 0, 0, 0, 0);
      add_step(ACT_READ,   CH_NUL, 11'd2047, 1, 1'b1, 0, 0, 0, 0, 0);
      add_step(ACT_READ,   CH_NUL, 11'd2000, 1, 1'b1, 0, 0, 0, 0, 0);
      add_step(ACT_UNUSED, 8'hFF,  11'h7FF,  1, 1'b1, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    CH_NUL, 11'd0,    1, 1'b1, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    CH_TAB, 11'd0,    1, 1'b1, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    CH_BS,  11'd0,    1, 1'b1, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    8'h41,  11'd0,    1, 1'b1, 1, 1, 0, 0, 0);
      add_step(ACT_PUT,    8'hFF,  11'h7FF,  1, 1'b1, 2, 2, 0, 0, 0);
      add_step(ACT_READ,   CH_NUL, 11'd1,    1, 1'b1, 2, 2, 0, 8'hFF, ATTR_ROSE);
      add_step(ACT_READ,   CH_NUL, 11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    CH_LF,  11'd0,    1, 1'b1, 80, 0, 1, 0, 0);
      add_step(ACT_PUT,    CH_CR,  11'd0,    1, 1'b1, 160, 0, 2, 0, 0);
      add_step(ACT_PUT,    CH_BS,  11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    8'h78,  11'd0,   80, 1'b0, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    CH_BS,  11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    CH_BS,  11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    CH_LF,  11'd0,   24, 1'b0, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    8'h7E,  11'd0,   80, 1'b0, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    8'h71,  11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    CH_BS,  11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    8'h79,  11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
      add_step(ACT_CLEAR,  8'h80,  11'd1024, 1, 1'b1, 0, 0, 0, 0, 0);
      add_step(ACT_PUT,    CH_BS,  11'd0,    1, 1'b1, 0, 0, 0, 0, 0);
      add_step(ACT_READ,   CH_NUL, 11'd1999, 1, 1'b0, 0, 0, 0, 0, 0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // hold off until the power-on clearing pass is over
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);

      set_colour(COLOUR_ROSE);
      foreach (script[i]) begin
         s = script[i];
         repeat (int'(s.reps)) issue_request(s.act, s.ch, s.idx, s.typed, s.rep);
      end

      settle();
      set_colour(COLOUR_KEEP);
      run_random(200);

      settle();
      set_colour(COLOUR_GREEN);
      send_idle_pct = 81;
      run_random(200);

      settle();
      set_colour(COLOUR_BLUE);
      send_idle_pct = 0;
      stall_pct = 81;
      run_random(200);

      settle();
      set_colour(COLOUR_KEEP);
      send_idle_pct = 26;
      stall_pct = 26;
      run_random(200);

      settle();
      set_colour(COLOUR_ROSE);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_asks = hold_asks + 1;
      run_random(60);

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (bad_reports == 0 && pending_reports.size() == 0)
         $display("text_console_cell_writer_core: match");
      else
         $display("text_console_cell_writer_core: mismatch");
      $finish;
   end

endmodule

@@ text_console_cell_writer_core.f @@
rtl/core/tccw_pkg.sv
rtl/core/tccw_ram.sv
rtl/core/text_console_cell_writer_core.sv
bench/tb.sv
